// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the FLV tag deframer. All of them
// sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define FLVD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by another one on the next edge.
`define FLVD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/flvd_pkg.sv =====
// ----------------------------------------------------------------------------
// FLV deframer package
// Widths, codes, parser phases and the result record shared by the block.
// ----------------------------------------------------------------------------
package flvd_pkg;

    // Field widths.
    localparam int BYTE_W    = 8;
    localparam int SIZE_W    = 24;
    localparam int PTS_W     = 25;
    localparam int CODEC_W   = 4;
    localparam int FMT_W     = 4;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 1;
    // Signed header remainder: tag size minus up to five header bytes.
    localparam int HDR_W     = SIZE_W + 2;

    // Tag types.
    localparam logic [BYTE_W-1:0] AUDIO_TAG = 8'h08;
    localparam logic [BYTE_W-1:0] VIDEO_TAG = 8'h09;

    // Codec identifiers.
    localparam logic [CODEC_W-1:0] PCM_CODEC     = 4'd0;
    localparam logic [CODEC_W-1:0] PCM_LE_CODEC  = 4'd3;
    localparam logic [CODEC_W-1:0] VP6_CODEC     = 4'd4;
    localparam logic [CODEC_W-1:0] VP6A_CODEC    = 4'd5;
    localparam logic [CODEC_W-1:0] NELLY8K_CODEC = 4'd5;
    localparam logic [CODEC_W-1:0] H264_CODEC    = 4'd7;
    localparam logic [CODEC_W-1:0] AAC_CODEC     = 4'd10;

    // Samples in one AAC frame.
    localparam logic [SIZE_W-1:0] AAC_FRAME = 24'd1024;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_AUDIO_EN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_VIDEO_EN = 1'b1;

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_PREV  = 4'd0,
        PH_TYPE  = 4'd1,
        PH_SIZE  = 4'd2,
        PH_TIME  = 4'd3,
        PH_RSV   = 4'd4,
        PH_FLAGS = 4'd5,
        PH_VP6   = 4'd6,
        PH_PKT   = 4'd7,
        PH_CTS   = 4'd8,
        PH_EMIT  = 4'd9,
        PH_SKIP  = 4'd10
    } phase_t;

    // One result beat.
    typedef struct packed {
        kind_t               kind;
        logic                is_video;
        logic [BYTE_W-1:0]   data_byte;
        logic [CODEC_W-1:0]  codec_id;
        logic [SIZE_W-1:0]   dts;
        logic [PTS_W-1:0]    pts;
        logic                keyframe;
        logic [SIZE_W-1:0]   payload_length;
        logic [FMT_W-1:0]    audio_format;
        logic [SIZE_W-1:0]   duration;
        logic                last;
    } result_t;

endpackage

// ===== rtl/flvd_byte_if.sv =====
// ----------------------------------------------------------------------------
// FLV byte stream channel
// Valid/ready channel carrying one byte of the FLV body per beat.
// ----------------------------------------------------------------------------
interface flvd_byte_if import flvd_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);

endinterface

// ===== rtl/flvd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface flvd_cfg_if import flvd_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic                 data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

// ===== rtl/flvd_res_if.sv =====
// ----------------------------------------------------------------------------
// Deframer result channel
// Valid/ready channel carrying one payload, codec header or error beat.
// ----------------------------------------------------------------------------
interface flvd_res_if import flvd_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic               is_video;
    logic [BYTE_W-1:0]  data_byte;
    logic [CODEC_W-1:0] codec_id;
    logic [SIZE_W-1:0]  dts;
    logic [PTS_W-1:0]   pts;
    logic               keyframe;
    logic [SIZE_W-1:0]  payload_length;
    logic [FMT_W-1:0]   audio_format;
    logic [SIZE_W-1:0]  duration;
    logic               last;

    modport source (
        output valid, output kind, output is_video, output data_byte, output codec_id,
        output dts, output pts, output keyframe, output payload_length,
        output audio_format, output duration, output last,
        input  ready
    );
    modport sink (
        input  valid, input kind, input is_video, input data_byte, input codec_id,
        input  dts, input pts, input keyframe, input payload_length,
        input  audio_format, input duration, input last,
        output ready
    );

endinterface

// ===== rtl/flv_tag_deframer.sv =====
// ----------------------------------------------------------------------------
// FLV tag deframer
// Splits an FLV tag stream into audio and video payload and codec header
// bytes with their timing and format fields, and flags bad payload sizes.
// ----------------------------------------------------------------------------
// Result path: a result beat is formed from the accepted byte that causes it
// and is registered in the output stage before it reaches the result channel.
// Throughput: one byte per cycle while the skid entry is free; the
// two-entry output stage keeps input ready registered.
// Reset: clears the parser to wait for a previous-tag-size field, forgets the
// latched codecs and headers, clears the halt, and sets both enables to 1.
module flv_tag_deframer import flvd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    flvd_byte_if.sink   stream,
    flvd_cfg_if.sink    cfg,
    flvd_res_if.source  result
);

    logic    res_valid;
    result_t res;
    logic    up_ready;

    // Tag parser.
    flvd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream),
        .cfg       (cfg),
        .in_ready  (up_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register stage.
    flvd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .up_ready  (up_ready),
        .result    (result)
    );

endmodule

// ===== rtl/flvd_parser.sv =====
// ----------------------------------------------------------------------------
// FLV tag parser
// Walks the tag header fields byte by byte, latches codecs and formats, and
// forms one result beat per payload or codec header byte, or an error.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flvd_parser import flvd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    flvd_byte_if.sink  stream,
    flvd_cfg_if.sink   cfg,
    input  logic       in_ready,
    output logic       res_valid,
    output result_t    res
);

    phase_t                  phase_reg, phase_next;
    logic [1:0]              cnt_reg, cnt_next;
    logic [BYTE_W-1:0]       tag_kind_reg, tag_kind_next;
    logic [SIZE_W-1:0]       tag_size_reg, tag_size_next;
    logic [SIZE_W-1:0]       bytes_left_reg, bytes_left_next;
    logic [SIZE_W-1:0]       tag_time_reg, tag_time_next;
    logic [SIZE_W-1:0]       comp_reg, comp_next;
    logic [BYTE_W-1:0]       flags_reg, flags_next;
    logic [SIZE_W-1:0]       pay_len_reg, pay_len_next;
    kind_t                   emit_kind_reg, emit_kind_next;
    logic signed [HDR_W-1:0] hdr_rem_reg, hdr_rem_next;
    logic                    seq_hdr_reg, seq_hdr_next;
    logic [CODEC_W:0]        audio_codec_reg, audio_codec_next;
    logic [CODEC_W:0]        video_codec_reg, video_codec_next;
    logic [FMT_W-1:0]        audio_fmt_reg, audio_fmt_next;
    logic [1:0]              header_seen_reg, header_seen_next;
    logic                    halted_reg, halted_next;
    logic                    audio_en_reg, audio_en_next;
    logic                    video_en_reg, video_en_next;

    logic [BYTE_W-1:0]       b;
    logic                    accept;
    logic                    live;
    logic                    is_vid;
    logic [CODEC_W-1:0]      acodec_now;
    logic [CODEC_W-1:0]      vcodec_now;
    logic [CODEC_W-1:0]      codec_reg;
    logic [CODEC_W-1:0]      codec_now;
    logic                    vp6;
    logic                    pkt_codec;
    logic signed [HDR_W-1:0] hdr_base;
    logic signed [HDR_W-1:0] hdr_cand;
    logic                    nonpos;
    logic                    cts_done;
    logic                    err_check;
    logic                    err_hit;
    logic [SIZE_W-1:0]       bytes_dec;
    logic                    seq_now;
    logic [1:0]              hdr_bit;
    logic                    first_hdr;
    logic [1:0]              align_sh;

    // Handshakes: configuration is always taken, bytes follow the output stage.
    assign stream.ready = in_ready;
    assign cfg.ready    = 1'b1;
    assign b            = stream.stream_byte;
    assign accept       = stream.valid && in_ready;
    assign live         = accept && !halted_reg;

    // Shared decode of the current byte against the parser state.
    always_comb
    begin
        is_vid     = (tag_kind_reg == VIDEO_TAG);
        acodec_now = audio_codec_reg[CODEC_W] ? audio_codec_reg[CODEC_W-1:0]
                                              : b[BYTE_W-1:FMT_W];
        vcodec_now = video_codec_reg[CODEC_W] ? video_codec_reg[CODEC_W-1:0]
                                              : b[CODEC_W-1:0];
        codec_reg  = is_vid ? video_codec_reg[CODEC_W-1:0] : audio_codec_reg[CODEC_W-1:0];
        codec_now  = (phase_reg == PH_FLAGS) ? (is_vid ? vcodec_now : acodec_now) : codec_reg;
        vp6        = is_vid && ((codec_now == VP6_CODEC) || (codec_now == VP6A_CODEC));
        pkt_codec  = is_vid ? (codec_now == H264_CODEC) : (codec_now == AAC_CODEC);
        // One subtractor serves every header byte count update.
        hdr_base   = (phase_reg == PH_FLAGS) ? $signed({2'b00, tag_size_reg}) : hdr_rem_reg;
        hdr_cand   = hdr_base - ((phase_reg == PH_CTS) ? HDR_W'(3) : HDR_W'(1));
        nonpos     = hdr_cand[HDR_W-1] || (hdr_cand == '0);
        cts_done   = (phase_reg == PH_CTS) && (cnt_reg == 2'd2);
        err_check  = ((phase_reg == PH_FLAGS) && !vp6 && !pkt_codec) ||
                     (phase_reg == PH_VP6) || (phase_reg == PH_PKT) || cts_done;
        err_hit    = live && err_check && nonpos;
        bytes_dec  = (bytes_left_reg != '0) ? bytes_left_reg - SIZE_W'(1) : '0;
        seq_now    = (phase_reg == PH_PKT) ? (b == '0) : seq_hdr_reg;
        hdr_bit    = is_vid ? 2'b10 : 2'b01;
        first_hdr  = (header_seen_reg & hdr_bit) == 2'b00;
        align_sh   = {1'b0, audio_fmt_reg[0]} + {1'b0, audio_fmt_reg[1]};
    end

    // Next state of the parser.
    always_comb
    begin
        phase_next       = phase_reg;
        cnt_next         = cnt_reg;
        tag_kind_next    = tag_kind_reg;
        tag_size_next    = tag_size_reg;
        bytes_left_next  = bytes_left_reg;
        tag_time_next    = tag_time_reg;
        comp_next        = comp_reg;
        flags_next       = flags_reg;
        pay_len_next     = pay_len_reg;
        emit_kind_next   = emit_kind_reg;
        hdr_rem_next     = hdr_rem_reg;
        seq_hdr_next     = seq_hdr_reg;
        audio_codec_next = audio_codec_reg;
        video_codec_next = video_codec_reg;
        audio_fmt_next   = audio_fmt_reg;
        header_seen_next = header_seen_reg;
        halted_next      = halted_reg || err_hit;
        audio_en_next    = audio_en_reg;
        video_en_next    = video_en_reg;

        if (cfg.valid)
        begin
            case (cfg.index)
                REG_AUDIO_EN: audio_en_next = cfg.data;
                REG_VIDEO_EN: video_en_next = cfg.data;
                default:      ;
            endcase
        end

        if (live && !err_hit)
        begin
            case (phase_reg)
                PH_PREV:
                begin
                    if (cnt_reg == 2'd3)
                    begin
                        cnt_next   = '0;
                        phase_next = PH_TYPE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
                PH_TYPE:
                begin
                    tag_kind_next = b;
                    tag_size_next = '0;
                    cnt_next      = '0;
                    phase_next    = PH_SIZE;
                end
                PH_SIZE:
                begin
                    tag_size_next = {tag_size_reg[SIZE_W-BYTE_W-1:0], b};
                    if (cnt_reg == 2'd2)
                    begin
                        cnt_next      = '0;
                        tag_time_next = '0;
                        phase_next    = PH_TIME;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
                PH_TIME:
                begin
                    tag_time_next = {tag_time_reg[SIZE_W-BYTE_W-1:0], b};
                    if (cnt_reg == 2'd2)
                    begin
                        cnt_next   = '0;
                        phase_next = PH_RSV;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
                PH_RSV:
                begin
                    if (cnt_reg == 2'd3)
                    begin
                        cnt_next  = '0;
                        comp_next = '0;
                        if (((tag_kind_reg == AUDIO_TAG) && audio_en_reg) ||
                            ((tag_kind_reg == VIDEO_TAG) && video_en_reg))
                        begin
                            phase_next = PH_FLAGS;
                        end
                        else if (tag_size_reg == '0)
                        begin
                            phase_next = PH_PREV;
                        end
                        else
                        begin
                            bytes_left_next = tag_size_reg;
                            phase_next      = PH_SKIP;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
                PH_FLAGS:
                begin
                    flags_next   = b;
                    hdr_rem_next = hdr_cand;
                    seq_hdr_next = 1'b0;
                    // The first tag of each stream fixes its codec.
                    if (is_vid)
                    begin
                        video_codec_next = {1'b1, vcodec_now};
                    end
                    else if (!audio_codec_reg[CODEC_W])
                    begin
                        audio_codec_next = {1'b1, acodec_now};
                        audio_fmt_next   = b[FMT_W-1:0];
                        if (b[BYTE_W-1:FMT_W] == NELLY8K_CODEC)
                        begin
                            audio_fmt_next[0] = 1'b0;
                        end
                    end
                    if (vp6)
                    begin
                        phase_next = PH_VP6;
                    end
                    else if (pkt_codec)
                    begin
                        phase_next = PH_PKT;
                    end
                    else
                    begin
                        pay_len_next    = hdr_cand[SIZE_W-1:0];
                        bytes_left_next = hdr_cand[SIZE_W-1:0];
                        emit_kind_next  = KIND_PAYLOAD;
                        phase_next      = PH_EMIT;
                    end
                end
                PH_VP6:
                begin
                    hdr_rem_next    = hdr_cand;
                    pay_len_next    = hdr_cand[SIZE_W-1:0];
                    bytes_left_next = hdr_cand[SIZE_W-1:0];
                    emit_kind_next  = KIND_PAYLOAD;
                    phase_next      = PH_EMIT;
                end
                PH_PKT, PH_CTS:
                begin
                    if (phase_reg == PH_PKT)
                    begin
                        seq_hdr_next = seq_now;
                    end
                    else
                    begin
                        comp_next = {comp_reg[SIZE_W-BYTE_W-1:0], b};
                        cnt_next  = cts_done ? 2'd0 : cnt_reg + 2'd1;
                    end
                    if ((phase_reg == PH_PKT) && is_vid)
                    begin
                        hdr_rem_next = hdr_cand;
                        cnt_next     = '0;
                        comp_next    = '0;
                        phase_next   = PH_CTS;
                    end
                    else if ((phase_reg == PH_PKT) || cts_done)
                    begin
                        // Packet header complete: sequence header or media data.
                        hdr_rem_next = hdr_cand;
                        if (seq_now && !first_hdr)
                        begin
                            bytes_left_next = hdr_cand[SIZE_W-1:0];
                            phase_next      = PH_SKIP;
                        end
                        else
                        begin
                            if (seq_now)
                            begin
                                header_seen_next = header_seen_reg | hdr_bit;
                            end
                            pay_len_next    = hdr_cand[SIZE_W-1:0];
                            bytes_left_next = hdr_cand[SIZE_W-1:0];
                            emit_kind_next  = seq_now ? KIND_HEADER : KIND_PAYLOAD;
                            phase_next      = PH_EMIT;
                        end
                    end
                end
                PH_EMIT, PH_SKIP:
                begin
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == '0)
                    begin
                        phase_next = PH_PREV;
                    end
                end
                default:
                begin
                    phase_next = PH_PREV;
                    cnt_next   = '0;
                end
            endcase
        end
    end

    // Result beat for the current byte.
    always_comb
    begin
        res_valid = err_hit || (live && (phase_reg == PH_EMIT));
        res       = '0;
        if (err_hit)
        begin
            res.kind     = KIND_ERROR;
            res.is_video = is_vid;
            res.codec_id = codec_now;
        end
        else
        begin
            res.kind           = emit_kind_reg;
            res.is_video       = is_vid;
            res.data_byte      = b;
            res.codec_id       = codec_reg;
            res.dts            = tag_time_reg;
            res.pts            = (is_vid && (codec_reg == H264_CODEC))
                                 ? {1'b0, tag_time_reg} + {1'b0, comp_reg}
                                 : {1'b0, tag_time_reg};
            res.keyframe       = is_vid ? (flags_reg[BYTE_W-1:FMT_W] == 4'd1) : 1'b1;
            res.payload_length = pay_len_reg;
            res.last           = (bytes_dec == '0);
            if (!is_vid)
            begin
                res.audio_format = audio_fmt_reg;
                if (emit_kind_reg == KIND_PAYLOAD)
                begin
                    // PCM block align is 1, 2 or 4 bytes, so the divide is a shift.
                    if ((codec_reg == PCM_CODEC) || (codec_reg == PCM_LE_CODEC))
                    begin
                        res.duration = pay_len_reg >> align_sh;
                    end
                    else if (codec_reg == AAC_CODEC)
                    begin
                        res.duration = AAC_FRAME;
                    end
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_PREV;
            cnt_reg         <= '0;
            tag_kind_reg    <= '0;
            tag_size_reg    <= '0;
            bytes_left_reg  <= '0;
            tag_time_reg    <= '0;
            comp_reg        <= '0;
            flags_reg       <= '0;
            pay_len_reg     <= '0;
            emit_kind_reg   <= KIND_PAYLOAD;
            hdr_rem_reg     <= '0;
            seq_hdr_reg     <= 1'b0;
            audio_codec_reg <= '0;
            video_codec_reg <= '0;
            audio_fmt_reg   <= '0;
            header_seen_reg <= '0;
            halted_reg      <= 1'b0;
            audio_en_reg    <= 1'b1;
            video_en_reg    <= 1'b1;
        end
        else
        begin
            phase_reg       <= phase_next;
            cnt_reg         <= cnt_next;
            tag_kind_reg    <= tag_kind_next;
            tag_size_reg    <= tag_size_next;
            bytes_left_reg  <= bytes_left_next;
            tag_time_reg    <= tag_time_next;
            comp_reg        <= comp_next;
            flags_reg       <= flags_next;
            pay_len_reg     <= pay_len_next;
            emit_kind_reg   <= emit_kind_next;
            hdr_rem_reg     <= hdr_rem_next;
            seq_hdr_reg     <= seq_hdr_next;
            audio_codec_reg <= audio_codec_next;
            video_codec_reg <= video_codec_next;
            audio_fmt_reg   <= audio_fmt_next;
            header_seen_reg <= header_seen_next;
            halted_reg      <= halted_next;
            audio_en_reg    <= audio_en_next;
            video_en_reg    <= video_en_next;
        end
    end

    // Once halted, no further beats come out, and an error always halts.
    `FLVD_ASSERT(a_halted_silent, !(halted_reg && res_valid), "beat produced while halted")
    `FLVD_ASSERT_NEXT(a_error_halts, res_valid && (res.kind == KIND_ERROR), halted_reg, "error did not halt the parser")
    `FLVD_ASSERT_NEXT(a_codec_sticky, video_codec_reg[CODEC_W], video_codec_reg == $past(video_codec_reg), "latched video codec changed")

endmodule

// ===== rtl/flvd_skid.sv =====
// ----------------------------------------------------------------------------
// Result output stage
// Two-entry skid register between the parser and the result channel, so the
// byte input stays ready on a registered signal while results wait.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flvd_skid import flvd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_valid,
    input  result_t     res,
    output logic        up_ready,
    flvd_res_if.source  result
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    out_fire;

    assign up_ready = !skid_valid_reg;
    assign out_fire = main_valid_reg && result.ready;

    // Fill the main register first; park in the skid entry when it is stalled.
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (res_valid)
        begin
            if (!main_valid_reg || out_fire)
            begin
                main_next       = res;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            main_next       = skid_reg;
            main_valid_next = skid_valid_reg;
            skid_valid_next = 1'b0;
        end
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    // Result channel outputs.
    assign result.valid          = main_valid_reg;
    assign result.kind           = main_reg.kind;
    assign result.is_video       = main_reg.is_video;
    assign result.data_byte      = main_reg.data_byte;
    assign result.codec_id       = main_reg.codec_id;
    assign result.dts            = main_reg.dts;
    assign result.pts            = main_reg.pts;
    assign result.keyframe       = main_reg.keyframe;
    assign result.payload_length = main_reg.payload_length;
    assign result.audio_format   = main_reg.audio_format;
    assign result.duration       = main_reg.duration;
    assign result.last           = main_reg.last;

    // The skid entry is only used behind a full main register, never overrun,
    // and drains into the main register on the next delivered beat.
    `FLVD_ASSERT(a_skid_behind_main, !skid_valid_reg || main_valid_reg, "skid entry valid with main empty")
    `FLVD_ASSERT(a_no_overrun, !(res_valid && skid_valid_reg), "result arrived with skid full")
    `FLVD_ASSERT_NEXT(a_skid_drains, out_fire && skid_valid_reg, main_valid_reg && !skid_valid_reg, "skid entry did not drain")

endmodule
